/* rtl/ssbm_pkg.sv */
// Shared types and constants for the surface sample best-match block.
package ssbm_pkg;
  localparam int Entries = 256;
  localparam int IdxW = $clog2(Entries);
  localparam int CntW = IdxW + 1;
  localparam int EntryW = 160;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        owner_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [15:0]        light_r;
    logic [15:0]        light_g;
    logic [15:0]        light_b;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  match_index;
    logic [15:0] out_r;
    logic [15:0] out_g;
    logic [15:0] out_b;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        owner;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [15:0]        lr;
    logic [15:0]        lg;
    logic [15:0]        lb;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // latch the query item
    logic clear;     // empty the table
    logic load;      // write the item at the fill count
    logic rd_en;     // read entry at scan index
    logic scan_rst;  // restart the scan
    logic eval;      // evaluate the entry held in the stage registers
  } ssbm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic scan_last;  // scan index is the last loaded entry
    logic empty;
  } ssbm_sts_t;
endpackage

/* rtl/ssbm_if.sv */
// Valid/ready channel interface carrying one item.
interface ssbm_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/surface_sample_best_match_top.sv */
// Surface sample best-match search: a table of up to 256 samples loaded one
// per transfer, searched by a query for the same owner with the lowest
// distance-plus-facing score. A query reads the table memory one entry per
// cycle and then drains the compare pipeline; its single result is held in an
// output register until taken. Clear, load, a dropped load and an item of the
// unused mode 3 give no result.
module surface_sample_best_match_top (
  input logic clk,
  input logic rst_n,
  ssbm_if.sink   in_ch,
  ssbm_if.source out_ch
);
  import ssbm_pkg::*;

  ssbm_cmd_t cmd;
  ssbm_sts_t sts;
  out_item_t result;
  out_item_t res_r;
  logic      out_valid;
  in_item_t  item;

  assign item = in_ch.data;

  ssbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_mode  (item.mode),
    .out_valid(out_valid),
    .out_ready(out_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ssbm_dp u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts),
    .item  (item),
    .result(result)
  );

  // Result is sampled in the cycle before it is shown and held until taken.
  logic load_res;
  assign load_res = !out_valid || out_ch.ready;
  always_ff @(posedge clk) begin
    if (load_res) begin
      res_r <= result;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = res_r;
endmodule

/* rtl/ssbm_ram.sv */
// Generic single-port RAM with registered read.
module ssbm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end
endmodule

/* rtl/ssbm_dp.sv */
// Datapath: sample table, fill count, scan index and score compare.
module ssbm_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  ssbm_pkg::ssbm_cmd_t cmd,
  output ssbm_pkg::ssbm_sts_t sts,
  input  ssbm_pkg::in_item_t  item,
  output ssbm_pkg::out_item_t result
);
  import ssbm_pkg::*;

  logic [CntW-1:0] count_r, count_nxt;
  logic [IdxW-1:0] scan_r, scan_nxt, eval_idx_r;
  in_item_t        q_r;
  entry_t          wentry, rentry;
  logic [EntryW-1:0] rdata;
  logic            found_ok_r;
  logic [IdxW-1:0] best_r;
  logic signed [47:0] low_score_r;
  logic [15:0]     br_r, bg_r, bb_r;

  // Stage registers between the products and the compare.
  logic            s1_vld_r;
  logic            s1_match_r;
  logic signed [33:0] s1_dot_r;
  logic [33:0]     s1_dx2_r, s1_dy2_r, s1_dz2_r;
  logic [IdxW-1:0] s1_idx_r;
  logic [15:0]     s1_lr_r, s1_lg_r, s1_lb_r;

  logic            rd_vld_r;

  always_comb begin
    wentry = '{owner: item.owner_id, px: item.pos_x, py: item.pos_y, pz: item.pos_z,
               nx: item.norm_x, ny: item.norm_y, nz: item.norm_z,
               lr: item.light_r, lg: item.light_g, lb: item.light_b};
  end

  ssbm_ram #(.Width(EntryW), .Depth(Entries)) u_ram (
    .clk  (clk),
    .we   (cmd.load && !sts.full),
    .re   (cmd.rd_en),
    .addr (cmd.load ? count_r[IdxW-1:0] : scan_r),
    .wdata(wentry),
    .rdata(rdata)
  );
  assign rentry = entry_t'(rdata);

  assign sts.full = (count_r == CntW'(Entries));
  assign sts.empty = (count_r == '0);
  assign sts.scan_last = ({1'b0, scan_r} == count_r - CntW'(1));

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (cmd.load && !sts.full) begin
      count_nxt = count_r + CntW'(1);
    end
    scan_nxt = scan_r;
    if (cmd.scan_rst) begin
      scan_nxt = '0;
    end else if (cmd.rd_en) begin
      scan_nxt = scan_r + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      scan_r   <= '0;
      rd_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      scan_r   <= scan_nxt;
      rd_vld_r <= cmd.rd_en;
      s1_vld_r <= rd_vld_r;
    end
  end

  // Stage 1: products of the entry read last cycle against the query.
  logic signed [16:0] dx, dy, dz;
  logic signed [33:0] dx2, dy2, dz2;
  logic signed [31:0] pnx, pny, pnz;
  always_comb begin
    dx  = 17'(rentry.px) - 17'(q_r.pos_x);
    dy  = 17'(rentry.py) - 17'(q_r.pos_y);
    dz  = 17'(rentry.pz) - 17'(q_r.pos_z);
    dx2 = dx * dx;
    dy2 = dy * dy;
    dz2 = dz * dz;
    pnx = rentry.nx * q_r.norm_x;
    pny = rentry.ny * q_r.norm_y;
    pnz = rentry.nz * q_r.norm_z;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_r <= item;
    end
    if (rd_vld_r) begin
      s1_dx2_r   <= dx2;
      s1_dy2_r   <= dy2;
      s1_dz2_r   <= dz2;
      s1_dot_r   <= 34'(pnx) + 34'(pny) + 34'(pnz);
      s1_match_r <= (rentry.owner == q_r.owner_id);
      s1_idx_r   <= eval_idx_r;
      s1_lr_r    <= rentry.lr;
      s1_lg_r    <= rentry.lg;
      s1_lb_r    <= rentry.lb;
    end
    if (cmd.rd_en) begin
      eval_idx_r <= scan_r;
    end
  end

  // Stage 2: facing test and score compare.
  logic [35:0]        dist_sq;
  logic signed [47:0] score;
  logic               facing_ok;
  always_comb begin
    dist_sq = 36'(s1_dx2_r) + 36'(s1_dy2_r) + 36'(s1_dz2_r);
    score = (48'(dist_sq) <<< 13) + (48'sd268435456 - 48'(s1_dot_r));
    facing_ok = !(s1_dot_r < -34'sd67108864);
  end

  logic s1_match;
  assign s1_match = facing_ok;

  always_ff @(posedge clk) begin
    if (cmd.eval && s1_vld_r && s1_match_r && s1_match &&
        (!found_ok_r || score < low_score_r)) begin
      best_r      <= s1_idx_r;
      low_score_r <= score;
      br_r        <= s1_lr_r;
      bg_r        <= s1_lg_r;
      bb_r        <= s1_lb_r;
    end
  end

  // Set once some entry passes both the owner and the facing test.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.scan_rst) begin
      found_ok_r <= 1'b0;
    end else if (cmd.eval && s1_vld_r && s1_match_r && s1_match) begin
      found_ok_r <= 1'b1;
    end
  end

  always_comb begin
    result = '0;
    if (found_ok_r) begin
      result.found       = 1'b1;
      result.match_index = 8'(best_r);
      result.out_r       = br_r;
      result.out_g       = bg_r;
      result.out_b       = bb_r;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Entries)) else $error("fill count beyond table depth");
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> count_r == '0) else $error("clear did not empty table");
  a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && sts.full && !cmd.clear) |=> $stable(count_r))
    else $error("load into full table changed count");
  a_stage: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |=> s1_vld_r) else $error("pipeline stage lost");
endmodule

/* rtl/ssbm_ctrl.sv */
// Controller: accepts items, sequences the table scan and holds the result.
module ssbm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_mode,
  output logic                out_valid,
  input  logic                out_ready,
  output ssbm_pkg::ssbm_cmd_t cmd,
  input  ssbm_pkg::ssbm_sts_t sts
);
  import ssbm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DRAIN1, S_DRAIN2, S_DONE} state_t;
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   acc;

  // A new item waits while a query is in progress or a previous result still holds the output.
  assign in_ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign acc       = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.capture  = 1'b1;
          cmd.scan_rst = 1'b1;
          cmd.clear    = (in_mode == MODE_CLEAR);
          cmd.load     = (in_mode == MODE_LOAD);
          if (in_mode == MODE_QUERY) begin
            state_nxt = sts.empty ? S_DRAIN1 : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        cmd.eval  = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN1;
        end
      end
      S_DRAIN1: begin
        cmd.eval  = 1'b1;
        state_nxt = S_DRAIN2;
      end
      S_DRAIN2: begin
        cmd.eval  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("accepted while scanning");
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_valid_r) else $error("query gave no result");
  a_scan_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> cmd.rd_en) else $error("scan without read");
endmodule

/* tb/sv/tb_surface_sample_best_match_top.sv */
// Testbench for the surface sample best-match block: directed and random table traffic.
`timescale 1ns / 1ps
module tb_surface_sample_best_match_top;
  import ssbm_pkg::*;

  logic clk;
  logic rst_n;
  ssbm_if #(.T(in_item_t))  in_ch ();
  ssbm_if #(.T(out_item_t)) out_ch ();

  surface_sample_best_match_top u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  localparam int StallLimit = 20000;

  // Shadow of the sample table and fill count.
  entry_t    shadow_table [Entries];
  int        shadow_count;
  out_item_t match_queue [$];
  int        fail_count;
  int        idle_cycles;
  bit        gaps_on;
  bit        hold_sink;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Works out the result of one accepted item and updates the shadow table.
  task automatic predict_match(input in_item_t it);
    logic signed [63:0] dot;
    logic signed [63:0] dist_sq;
    logic signed [63:0] score;
    logic signed [63:0] low_score;
    logic signed [63:0] d;
    int                 best;
    bit                 hit;
    out_item_t          res;
    entry_t             e;
    if (it.mode == MODE_CLEAR) begin
      shadow_count = 0;
    end else if (it.mode == MODE_LOAD) begin
      if (shadow_count < Entries) begin
        shadow_table[shadow_count] = '{it.owner_id, it.pos_x, it.pos_y, it.pos_z,
          it.norm_x, it.norm_y, it.norm_z, it.light_r, it.light_g, it.light_b};
        shadow_count++;
      end
    end else if (it.mode == MODE_QUERY) begin
      hit = 0;
      best = 0;
      low_score = 0;
      for (int i = 0; i < shadow_count; i++) begin
        e = shadow_table[i];
        if (e.owner != it.owner_id) continue;
        dot = 64'(e.nx) * 64'(it.norm_x) + 64'(e.ny) * 64'(it.norm_y)
            + 64'(e.nz) * 64'(it.norm_z);
        if (dot < -(64'sd1 <<< 26)) continue;
        dist_sq = 0;
        d = 64'(e.px) - 64'(it.pos_x); dist_sq += d * d;
        d = 64'(e.py) - 64'(it.pos_y); dist_sq += d * d;
        d = 64'(e.pz) - 64'(it.pos_z); dist_sq += d * d;
        score = dist_sq * 64'sd8192 + ((64'sd1 <<< 28) - dot);
        if (!hit || score < low_score) begin
          hit = 1;
          best = i;
          low_score = score;
        end
      end
      res = '0;
      if (hit) begin
        res.found = 1'b1;
        res.match_index = best[7:0];
        res.out_r = shadow_table[best].lr;
        res.out_g = shadow_table[best].lg;
        res.out_b = shadow_table[best].lb;
      end
      match_queue = {match_queue, res};
    end
  endtask

  // Valid stays high after a transfer until the next call drives new data or a gap.
  task automatic send_item(input in_item_t it);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    predict_match(it);
  endtask

  function automatic logic [15:0] rand_norm();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  function automatic in_item_t rand_item(input logic [1:0] mode, input logic [15:0] owner,
                                         input bit near);
    in_item_t     it;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    it.mode = mode;
    it.owner_id = owner;
    if (near) begin
      it.pos_x = 16'($urandom_range(0, 1023) - 512);
      it.pos_y = 16'($urandom_range(0, 1023) - 512);
      it.pos_z = 16'($urandom_range(0, 1023) - 512);
    end
    it.norm_x = rand_norm();
    it.norm_y = rand_norm();
    it.norm_z = rand_norm();
    return it;
  endfunction

  // Waits until every query result has come back, then lets the pipeline drain.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (match_queue.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_directed();
    in_item_t it;
    send_item(rand_item(MODE_QUERY, 16'h0000, 0));
    it = rand_item(MODE_LOAD, 16'hFFFF, 0);
    it.pos_x = 16'sh7FFF; it.pos_y = 16'sh8000; it.pos_z = 16'sh7FFF;
    it.norm_x = 16'sd16384; it.norm_y = 0; it.norm_z = 0;
    it.light_r = 16'hFFFF; it.light_g = 0; it.light_b = 16'hFFFF;
    send_item(it);
    it.pos_x = 16'sh8000; it.pos_y = 16'sh7FFF; it.pos_z = 16'sh8000;
    it.norm_x = -16'sd16384; it.light_g = 16'hFFFF; it.light_r = 0;
    send_item(it);
    it.pos_x = 16'sh8000; it.norm_x = -16'sd4096; it.norm_y = 16'sd15852;
    send_item(it);
    it.pos_y = 16'sh8000; it.norm_x = 16'sd16384; it.norm_y = 0;
    send_item(it);
    // Tie: a duplicate of an earlier entry must not win.
    send_item(it);
    it.mode = MODE_QUERY;
    send_item(it);
    it.norm_x = -16'sd16384;
    send_item(it);
    it.norm_x = 0; it.norm_y = 16'sd16384;
    send_item(it);
    it.owner_id = 16'h1234;
    send_item(it);
    // Over-long normals can drive the score negative.
    it = rand_item(MODE_LOAD, 16'h0001, 1);
    it.norm_x = 16'sh7FFF; it.norm_y = 16'sh7FFF; it.norm_z = 16'sh7FFF;
    send_item(it);
    it.mode = MODE_QUERY;
    send_item(it);
    it.norm_x = 16'sh8000; it.norm_y = 16'sh8000; it.norm_z = 16'sh8000;
    send_item(it);
    send_item(rand_item(2'd3, 16'h0001, 1));
    send_item(rand_item(MODE_QUERY, 16'h0001, 1));
    send_item(rand_item(MODE_CLEAR, 16'hABCD, 0));
    send_item(rand_item(MODE_QUERY, 16'hFFFF, 0));
    wait_drained();
  endtask

  // Fills the table past its end so that the extra loads are dropped.
  task automatic test_full_table();
    send_item(rand_item(MODE_CLEAR, 0, 0));
    for (int i = 0; i < Entries + 4; i++)
      send_item(rand_item(MODE_LOAD, 16'($urandom_range(0, 3)), 1));
    for (int i = 0; i < 12; i++)
      send_item(rand_item(MODE_QUERY, 16'($urandom_range(0, 4)), 1));
    wait_drained();
  endtask

  // Holds the result side off for a long stretch while queries keep coming.
  task automatic test_backpressure();
    send_item(rand_item(MODE_CLEAR, 0, 0));
    for (int i = 0; i < 6; i++) send_item(rand_item(MODE_LOAD, 16'h0007, 1));
    hold_sink = 1;
    for (int i = 0; i < 8; i++) send_item(rand_item(MODE_QUERY, 16'h0007, 1));
    wait_drained();
  endtask

  task automatic test_random(input int n_items);
    int n;
    int len;
    n = 0;
    while (n < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(rand_item(2'($urandom), 16'($urandom), 1'($urandom_range(0, 1))));
        n++;
      end else begin
        send_item(rand_item(MODE_CLEAR, 16'($urandom), 0));
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 16);
        for (int i = 0; i < len; i++)
          send_item(rand_item(MODE_LOAD, 16'($urandom_range(0, 2)), 1));
        for (int i = 0; i < 4; i++)
          send_item(rand_item(MODE_QUERY, 16'($urandom_range(0, 3)), 1));
        n += len + 5;
      end
    end
    wait_drained();
  endtask

  // Result side: random ready, and one long hold-off when asked.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_sink = 0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (match_queue.size() == 0) begin
        $error("unexpected result transfer %p", out_ch.data);
        fail_count++;
      end else begin
        want = match_queue.pop_front();
        if (out_ch.data.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_ch.data.found);
          fail_count++;
        end
        if (out_ch.data.match_index !== want.match_index) begin
          $error("match_index: expected %0d, got %0d", want.match_index,
                 out_ch.data.match_index);
          fail_count++;
        end
        if (out_ch.data.out_r !== want.out_r) begin
          $error("out_r: expected %h, got %h", want.out_r, out_ch.data.out_r);
          fail_count++;
        end
        if (out_ch.data.out_g !== want.out_g) begin
          $error("out_g: expected %h, got %h", want.out_g, out_ch.data.out_g);
          fail_count++;
        end
        if (out_ch.data.out_b !== want.out_b) begin
          $error("out_b: expected %h, got %h", want.out_b, out_ch.data.out_b);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("** surface_sample_best_match_top: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    shadow_count = 0;
    gaps_on = 1;
    hold_sink = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random(900);
    gaps_on = 0;
    test_random(350);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && match_queue.size() == 0) begin
      $display("** surface_sample_best_match_top: PASSED **");
    end else begin
      $display("** surface_sample_best_match_top: FAILED **");
    end
    $finish;
  end
endmodule
